@@ hdl/wpsa_pkg.sv @@
// package for the watchpoint slot allocator: sizes, codes and control word helpers
`default_nettype none

package wpsa_pkg;

    localparam int SLOTS           = 4;
    localparam int MAX_WATCH_BYTES = 16;

    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int HIT_SLOTS = (SLOTS < 4) ? SLOTS : 4;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 40;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_CHECK  = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    // control word layout, dr7 style
    localparam logic [31:0] CTL_SLOWDOWN   = 32'h0000_0100;
    localparam int          CTL_FIELD_BASE = 16;
    localparam logic [3:0]  RW_WRITE       = 4'h1;
    localparam logic [3:0]  LEN_1          = 4'h0;
    localparam logic [3:0]  LEN_2          = 4'h4;
    localparam logic [3:0]  LEN_4          = 4'hC;
    localparam logic [3:0]  FIELD_ALL      = 4'hF;

    localparam logic [3:0]  HIT_MASK = 4'((1 << HIT_SLOTS) - 1);

    // local enable bit of one slot, bits past the word are dropped
    function automatic logic [31:0] enable_bit(input logic [CNT_W-1:0] idx);
        logic [63:0] b;
        b = 64'd1 << (7'(idx) * 7'd2);
        return b[31:0];
    endfunction

    // rw/len field of one slot, bits past the word are dropped
    function automatic logic [31:0] field_bits(input logic [CNT_W-1:0] idx,
                                               input logic [3:0] v);
        logic [63:0] f;
        f = {60'd0, v} << (7'(CTL_FIELD_BASE) + 7'(idx) * 7'd4);
        return f[31:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/watchpoint_slot_allocator_top.sv @@
// watchpoint slot allocator: slot table, control word and request sequencer
//
// usage
//   s_axis: one request per transaction, tdata carries req_type, watch_addr,
//     watch_size, watch_tag, commit_ok, hit_status, status_valid
//   m_axis: one result per request, tdata carries ok, control_word, used_mask
//   requests are served one at a time; s_tready is high only while idle
// sequence
//   check, unused codes and oversize add: go straight to the finish state
//   add: one region piece placed or one occupied slot passed over per step,
//     then the finish state
//   remove: the tag/start compare visits one slot a cycle, then the finish state
//   the finish state loads the output register once it is free, then goes idle
// reset
//   aresetn low clears all slots and the control word, output goes invalid
// stall
//   the result sits in the output register; the next request may be taken
//   while it waits, but its own result is held until the register frees up
`default_nettype none

module watchpoint_slot_allocator_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [1:0] req_type, [33:2] watch_addr, [38:34] watch_size, [70:39] watch_tag,
    // [71] commit_ok, [75:72] hit_status, [76] status_valid, rest zero
    input  wire logic [wpsa_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] ok, [32:1] control_word, [36:33] used_mask, rest zero
    output logic [wpsa_pkg::M_TDATA_W-1:0]      m_tdata
);
    import wpsa_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_REMOVE,
        ST_FINISH
    } state_t;

    // input fields
    logic [1:0]  in_req_type;
    logic [31:0] in_watch_addr;
    logic [4:0]  in_watch_size;
    logic [31:0] in_watch_tag;
    logic        in_commit_ok;
    logic [3:0]  in_hit_status;
    logic        in_status_valid;

    assign in_req_type     = s_tdata[1:0];
    assign in_watch_addr   = s_tdata[33:2];
    assign in_watch_size   = s_tdata[38:34];
    assign in_watch_tag    = s_tdata[70:39];
    assign in_commit_ok    = s_tdata[71];
    assign in_hit_status   = s_tdata[75:72];
    assign in_status_valid = s_tdata[76];

    // slot table
    logic [31:0] slot_addr_reg  [SLOTS];
    logic [31:0] slot_start_reg [SLOTS];
    logic [31:0] slot_owner_reg [SLOTS];
    logic [31:0] slot_addr_next [SLOTS];
    logic [31:0] slot_start_next[SLOTS];
    logic [31:0] slot_owner_next[SLOTS];
    logic [31:0] control_reg, control_next;

    // sequencer
    state_t          state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;       // slot pointer, counts up to SLOTS
    logic [31:0]     addr_reg, addr_next;      // current piece address
    logic [31:0]     start_reg, start_next;    // region start
    logic [4:0]      size_reg, size_next;      // bytes still to place
    logic [31:0]     tag_reg, tag_next;
    logic            commit_reg, commit_next;
    logic [31:0]     ctl_work_reg, ctl_work_next; // working copy of the control word
    logic [SLOTS-1:0] touched_reg, touched_next;  // slots written by this add
    logic            found_reg, found_next;
    logic            ok_reg, ok_next;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic [3:0]       piece_len;
    logic [4:0]       piece_step;
    logic [3:0]       used_mask;
    logic             out_free;
    logic             s_fire;

    assign idx      = idx_reg[IDX_W-1:0];
    assign in_range = (32'(idx_reg) < 32'(SLOTS));
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // largest aligned piece that fits
    always_comb begin
        if (size_reg >= 5'd4 && addr_reg[1:0] == 2'b00) begin
            piece_len  = LEN_4;
            piece_step = 5'd4;
        end else if (size_reg >= 5'd2 && addr_reg[0] == 1'b0) begin
            piece_len  = LEN_2;
            piece_step = 5'd2;
        end else begin
            piece_len  = LEN_1;
            piece_step = 5'd1;
        end
    end

    always_comb begin
        used_mask = 4'd0;
        for (int i = 0; i < HIT_SLOTS; i++) begin
            used_mask[i] = (slot_addr_reg[i] != 32'd0);
        end
    end

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        addr_next     = addr_reg;
        start_next    = start_reg;
        size_next     = size_reg;
        tag_next      = tag_reg;
        commit_next   = commit_reg;
        ctl_work_next = ctl_work_reg;
        touched_next  = touched_reg;
        found_next    = found_reg;
        ok_next       = ok_reg;
        control_next  = control_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        for (int i = 0; i < SLOTS; i++) begin
            slot_addr_next[i]  = slot_addr_reg[i];
            slot_start_next[i] = slot_start_reg[i];
            slot_owner_next[i] = slot_owner_reg[i];
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    idx_next      = '0;
                    addr_next     = in_watch_addr;
                    start_next    = in_watch_addr;
                    size_next     = in_watch_size;
                    tag_next      = in_watch_tag;
                    commit_next   = in_commit_ok;
                    ctl_work_next = control_reg;
                    touched_next  = '0;
                    found_next    = 1'b0;
                    ok_next       = 1'b0;
                    case (req_type_t'(in_req_type))
                        REQ_ADD: begin
                            if (32'(in_watch_size) > 32'(MAX_WATCH_BYTES)) begin
                                state_next = ST_FINISH;
                            end else begin
                                state_next = ST_ADD;
                            end
                        end
                        REQ_REMOVE: begin
                            state_next = ST_REMOVE;
                        end
                        REQ_CHECK: begin
                            ok_next = (control_reg != 32'd0) && in_status_valid &&
                                      ((in_hit_status & HIT_MASK) != 4'd0);
                            state_next = ST_FINISH;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_ADD: begin
                if (size_reg == 5'd0 || !in_range) begin
                    // region placed, or slots ran out
                    if (size_reg == 5'd0 && commit_reg) begin
                        control_next = ctl_work_reg;
                        ok_next      = 1'b1;
                    end else begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (touched_reg[i]) begin
                                slot_addr_next[i]  = 32'd0;
                                slot_start_next[i] = 32'd0;
                                slot_owner_next[i] = 32'd0;
                            end
                        end
                        ok_next = 1'b0;
                    end
                    state_next = ST_FINISH;
                end else if (slot_addr_reg[idx] != 32'd0) begin
                    idx_next = idx_reg + CNT_W'(1);
                end else begin
                    // pointer stays: a piece at address zero leaves the slot free
                    slot_addr_next[idx]  = addr_reg;
                    slot_start_next[idx] = start_reg;
                    slot_owner_next[idx] = tag_reg;
                    touched_next[idx]    = 1'b1;
                    ctl_work_next = ctl_work_reg | CTL_SLOWDOWN | enable_bit(idx_reg) |
                                    field_bits(idx_reg, RW_WRITE | piece_len);
                    addr_next = addr_reg + 32'(piece_step);
                    size_next = size_reg - piece_step;
                end
            end

            ST_REMOVE: begin
                if (in_range) begin
                    if (slot_start_reg[idx] == start_reg && slot_owner_reg[idx] == tag_reg) begin
                        slot_addr_next[idx]  = 32'd0;
                        slot_start_next[idx] = 32'd0;
                        slot_owner_next[idx] = 32'd0;
                        ctl_work_next = ctl_work_reg & ~enable_bit(idx_reg) &
                                        ~field_bits(idx_reg, FIELD_ALL);
                        found_next = 1'b1;
                    end
                    idx_next = idx_reg + CNT_W'(1);
                end else begin
                    if (found_reg) begin
                        control_next = ctl_work_reg;
                    end
                    ok_next    = found_reg && commit_reg;
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'd0, used_mask, control_reg, ok_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            control_reg  <= 32'd0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_addr_reg[i]  <= 32'd0;
                slot_start_reg[i] <= 32'd0;
                slot_owner_reg[i] <= 32'd0;
            end
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            control_reg  <= control_next;
            for (int i = 0; i < SLOTS; i++) begin
                slot_addr_reg[i]  <= slot_addr_next[i];
                slot_start_reg[i] <= slot_start_next[i];
                slot_owner_reg[i] <= slot_owner_next[i];
            end
        end
        idx_reg      <= idx_next;
        addr_reg     <= addr_next;
        start_reg    <= start_next;
        size_reg     <= size_next;
        tag_reg      <= tag_next;
        commit_reg   <= commit_next;
        ctl_work_reg <= ctl_work_next;
        touched_reg  <= touched_next;
        found_reg    <= found_next;
        ok_reg       <= ok_next;
        m_tdata_reg  <= m_tdata_next;
    end

endmodule

`default_nettype wire
